FILE: rtl/core/plf_pkg.sv
package plf_pkg;

    localparam int CNT_W      = 4;
    localparam int ACC_W      = 21;
    localparam int MCAND_W    = 9;
    localparam int MPLIER_W   = 11;
    localparam int DVD_W      = 14;
    localparam int DVS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int STEER_W    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_TENTHS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD_TENTHS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALT_COLOR   = 3'd4;

    localparam logic [1:0] STOP_RED  = 2'd1;
    localparam logic [1:0] STOP_BLUE = 2'd2;

    localparam logic signed [7:0] SPEED_RST      = 8'sd50;
    localparam logic [6:0]        TARGET_RST     = 7'd50;
    localparam logic [7:0]        KP_RST         = 8'd19;
    localparam logic [10:0]       KD_RST         = 11'd1000;
    localparam logic [1:0]        HALT_COLOR_RST = STOP_RED;

    localparam logic signed [7:0] PWR_LIM    = 8'sd100;
    localparam logic [DVS_W-1:0]  GAIN_SCALE = 6'd10;
    localparam logic [DVS_W-1:0]  MIX_HALF   = 6'd50;
    localparam logic [ACC_W-1:0]  SUM_SAT    = 21'd1000;

    localparam logic [CNT_W-1:0] PD_BITS     = 4'd11;
    localparam logic [CNT_W-1:0] MIXMUL_BITS = 4'd7;
    localparam logic [CNT_W-1:0] STEER_BITS  = 4'd10;
    localparam logic [CNT_W-1:0] MIX_BITS    = 4'd14;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } unit_cmd_t;

endpackage

FILE: rtl/core/plf_serial_mul.sv
module plf_serial_mul
    import plf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  unit_cmd_t                  cmd,
    input  logic signed [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0]        mplier,
    output logic                       busy,
    output logic signed [ACC_W-1:0]    product
);

    // Shift-add multiplier: one multiplier bit is consumed per cycle.
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mc_reg, mc_next;
    logic [MPLIER_W-1:0]     mp_reg, mp_next;

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.nbits;
            acc_next = '0;
            mc_next  = {{(ACC_W-MCAND_W){mcand[MCAND_W-1]}}, mcand};
            mp_next  = mplier;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = mp_reg[0] ? (acc_reg + mc_reg) : acc_reg;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

endmodule

FILE: rtl/core/plf_serial_div.sv
module plf_serial_div
    import plf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  unit_cmd_t          cmd,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [DVS_W-1:0]   divisor,
    output logic               busy,
    output logic [DVD_W-1:0]   quotient
);

    // Restoring divider: the dividend is left aligned and one quotient bit
    // is produced per cycle.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_diff;
    logic             qbit;

    assign busy       = (cnt_reg != '0);
    assign quotient   = quo_reg;
    assign trial      = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign qbit       = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.nbits;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = dvd_reg << 1;
            rem_next = qbit ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: rtl/core/plf_color_detect.sv
module plf_color_detect
    import plf_pkg::*;
(
    input  logic [9:0] red,
    input  logic [9:0] green,
    input  logic [9:0] blue,
    input  logic [1:0] halt_color,
    output logic       found
);

    logic is_red;
    logic is_blue;

    assign is_red  = ({1'b0, red} > {green, 1'b0}) && ({1'b0, red} > {blue, 1'b0});
    assign is_blue = ({1'b0, blue} > {red, 1'b0}) && (blue > green);

    always_comb
    begin
        unique case (halt_color)
            STOP_RED:  found = is_red;
            STOP_BLUE: found = is_blue;
            default:   found = 1'b0;
        endcase
    end

endmodule

FILE: rtl/core/pd_line_follower_steering_top.sv
// PD line follower steering with a color stop.
// Input channel (in_valid/in_stall) carries one sensor sample per
// transaction: reflect, red_raw, green_raw and blue_raw. Output channel
// (out_valid/out_stall) returns one transaction per sample: left_power,
// right_power and color_found.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// writes speed, target_level, kp_tenths, kd_tenths and halt_color at
// indexes 0 to 4; cfg_ready is always high and other indexes are ignored.
// A new sample is not accepted while one is being worked on: in_stall is
// high until the result is loaded into the output register.
// Both PD products run at once on two bit-serial multipliers; one of them is
// then reused for the wheel mix product, and a single bit-serial divider
// does both the steering divide by ten and the divide by fifty.
// A finished result waits in the output register while the receiver
// stalls; the next sample is accepted and worked on meanwhile, and its
// result is held back until the output register is free.
// Reset restores the default register values and clears the stored
// previous reflection and the output valid.
module pd_line_follower_steering_top
    import plf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [6:0]             reflect,
    input  logic [9:0]             red_raw,
    input  logic [9:0]             green_raw,
    input  logic [9:0]             blue_raw,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [7:0]      left_power,
    output logic signed [7:0]      right_power,
    output logic                   color_found,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MULPD = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_STEER = 3'd4;
    localparam logic [2:0] S_WDIV1 = 3'd5;
    localparam logic [2:0] S_WMUL2 = 3'd6;
    localparam logic [2:0] S_WDIV2 = 3'd7;

    logic [2:0] state_reg, state_next;

    logic signed [7:0] speed_reg;
    logic [6:0]        target_reg;
    logic [7:0]        kp_reg;
    logic [10:0]       kd_reg;
    logic [1:0]        halt_color_reg;
    logic [6:0]        prev_reflect_reg;

    logic [6:0] refl_reg;
    logic [9:0] red_reg;
    logic [9:0] green_reg;
    logic [9:0] blue_reg;
    logic       found_reg;

    logic signed [ACC_W-1:0] sum_reg;

    logic              out_valid_reg;
    logic signed [7:0] left_reg;
    logic signed [7:0] right_reg;
    logic              color_reg;

    logic in_accept;
    logic out_load;
    logic item_found;

    logic signed [7:0] perr;
    logic signed [7:0] derr;
    logic signed [7:0] pwr;
    logic [6:0]        apwr;
    logic [ACC_W-1:0]  abs_sum;
    logic [STEER_W-1:0] steer_dvd;

    unit_cmd_t               mul_p_cmd;
    unit_cmd_t               mul_d_cmd;
    unit_cmd_t               div_cmd;
    logic signed [MCAND_W-1:0] mul_p_mcand;
    logic [MPLIER_W-1:0]     mul_p_mplier;
    logic                    mul_p_busy;
    logic                    mul_d_busy;
    logic signed [ACC_W-1:0] mul_p_prod;
    logic signed [ACC_W-1:0] mul_d_prod;
    logic [DVD_W-1:0]        div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic                    div_busy;
    logic [DVD_W-1:0]        div_q;

    logic signed [8:0] inner_mag;
    logic signed [8:0] inner9;
    logic signed [7:0] inner;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign left_power  = left_reg;
    assign right_power = right_reg;
    assign color_found = color_reg;
    assign out_load    = (state_reg == S_WDIV2) && !div_busy
                         && (!out_valid_reg || !out_stall);

    assign perr = $signed({1'b0, target_reg}) - $signed({1'b0, refl_reg});
    assign derr = $signed({1'b0, prev_reflect_reg}) - $signed({1'b0, refl_reg});

    always_comb
    begin
        priority if (speed_reg > PWR_LIM)
        begin
            pwr = PWR_LIM;
        end
        else if (speed_reg < -PWR_LIM)
        begin
            pwr = -PWR_LIM;
        end
        else
        begin
            pwr = speed_reg;
        end
    end

    assign apwr      = pwr[7] ? 7'(-pwr) : pwr[6:0];
    assign abs_sum   = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : sum_reg;
    assign steer_dvd = (abs_sum >= SUM_SAT) ? SUM_SAT[STEER_W-1:0]
                                            : abs_sum[STEER_W-1:0];

    assign mul_p_cmd.start = (state_reg == S_LOAD)
                             || ((state_reg == S_WDIV1) && !div_busy);
    assign mul_p_cmd.nbits = (state_reg == S_LOAD) ? PD_BITS : MIXMUL_BITS;
    assign mul_p_mcand     = (state_reg == S_WDIV1) ? {2'b00, apwr} : {perr[7], perr};
    assign mul_p_mplier    = (state_reg == S_WDIV1) ? {4'b0000, div_q[6:0]}
                                                    : {3'b000, kp_reg};

    assign mul_d_cmd.start = (state_reg == S_LOAD);
    assign mul_d_cmd.nbits = PD_BITS;

    assign div_cmd.start = (state_reg == S_STEER)
                           || ((state_reg == S_WMUL2) && !mul_p_busy);
    assign div_cmd.nbits = (state_reg == S_STEER) ? STEER_BITS : MIX_BITS;
    assign div_dvd       = (state_reg == S_STEER)
                           ? {steer_dvd, {(DVD_W-STEER_W){1'b0}}}
                           : mul_p_prod[DVD_W-1:0];
    assign div_dvs       = (state_reg == S_STEER) ? GAIN_SCALE : MIX_HALF;

    // The inner wheel is sign(pwr) * (|pwr| - |diff|), which already lies
    // within plus or minus |pwr|.
    assign inner_mag = $signed({2'b00, apwr}) - $signed({1'b0, div_q[7:0]});
    assign inner9    = pwr[7] ? -inner_mag : inner_mag;
    assign inner     = inner9[7:0];

    plf_serial_mul u_mul_p (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_p_cmd),
        .mcand   (mul_p_mcand),
        .mplier  (mul_p_mplier),
        .busy    (mul_p_busy),
        .product (mul_p_prod)
    );

    plf_serial_mul u_mul_d (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_d_cmd),
        .mcand   ({derr[7], derr}),
        .mplier  (kd_reg),
        .busy    (mul_d_busy),
        .product (mul_d_prod)
    );

    plf_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    plf_color_detect u_color (
        .red        (red_reg),
        .green      (green_reg),
        .blue       (blue_reg),
        .halt_color (halt_color_reg),
        .found      (item_found)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_MULPD;
            end
            S_MULPD:
            begin
                if (!mul_p_busy && !mul_d_busy)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_STEER;
            end
            S_STEER:
            begin
                state_next = S_WDIV1;
            end
            S_WDIV1:
            begin
                if (!div_busy)
                begin
                    state_next = S_WMUL2;
                end
            end
            S_WMUL2:
            begin
                if (!mul_p_busy)
                begin
                    state_next = S_WDIV2;
                end
            end
            S_WDIV2:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            speed_reg        <= SPEED_RST;
            target_reg       <= TARGET_RST;
            kp_reg           <= KP_RST;
            kd_reg           <= KD_RST;
            halt_color_reg   <= HALT_COLOR_RST;
            prev_reflect_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SPEED:        speed_reg      <= cfg_data[7:0];
                    REG_TARGET_LEVEL: target_reg     <= cfg_data[6:0];
                    REG_KP_TENTHS:    kp_reg         <= cfg_data[7:0];
                    REG_KD_TENTHS:    kd_reg         <= cfg_data[10:0];
                    REG_HALT_COLOR:   halt_color_reg <= cfg_data[1:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_LOAD)
            begin
                prev_reflect_reg <= item_found ? 7'd0 : refl_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            refl_reg  <= reflect;
            red_reg   <= red_raw;
            green_reg <= green_raw;
            blue_reg  <= blue_raw;
        end
        if (state_reg == S_LOAD)
        begin
            found_reg <= item_found;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= mul_p_prod + mul_d_prod;
        end
        if (out_load)
        begin
            left_reg  <= sum_reg[ACC_W-1] ? inner : pwr;
            right_reg <= sum_reg[ACC_W-1] ? pwr : inner;
            color_reg <= found_reg;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_LOAD))
        else $error("accepted sample did not start the computation");

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_power <= PWR_LIM) && (left_power >= -PWR_LIM)
                      && (right_power <= PWR_LIM) && (right_power >= -PWR_LIM))
        else $error("wheel power out of range");

    a_outer_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_power == pwr) || (right_power == pwr))
        else $error("neither wheel carries the base power");

    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_p_cmd.start |-> !mul_p_busy)
        else $error("multiplier started while busy");

    a_found_clears_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && found_reg) |-> (prev_reflect_reg == 7'd0))
        else $error("previous reflection not cleared on stop color");

endmodule

FILE: sim/tb_pd_line_follower_steering_top.sv
module tb_pd_line_follower_steering_top
    import plf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT = 900_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    localparam int MAG_LIMIT = 100;
    localparam int GAIN_DIV = 10;
    localparam int MIX_DIV = 50;

    localparam logic [1:0] STOP_NONE = 2'd0;
    localparam logic [1:0] STOP_SPARE = 2'd3;
    localparam int REG_UNUSED_FIRST = REG_HALT_COLOR + 1;
    localparam int REG_INDEX_TOP = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic [6:0] level;
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic              found;
    } wheels_t;

    typedef struct {
        int speed;
        int level;
        int kp;
        int kd;
        int stop;
    } settings_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [6:0]            reflect = '0;
    logic [9:0]            red_raw = '0;
    logic [9:0]            green_raw = '0;
    logic [9:0]            blue_raw = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [7:0]     left_power;
    logic signed [7:0]     right_power;
    logic                  color_found;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [7:0] speed_set = SPEED_RST;
    logic [6:0]        level_set = TARGET_RST;
    logic [7:0]        kp_set = KP_RST;
    logic [10:0]       kd_set = KD_RST;
    logic [1:0]        stop_set = HALT_COLOR_RST;
    logic [6:0]        last_level = '0;

    wheels_t     wheel_cmds_due[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          walk_level = 50;
    bit          tx_idle_on = 1'b1;
    logic        rx_stall_on = 1'b1;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int          hold_left = 0;
    int          run_left = 0;

    pd_line_follower_steering_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .reflect     (reflect),
        .red_raw     (red_raw),
        .green_raw   (green_raw),
        .blue_raw    (blue_raw),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_power  (left_power),
        .right_power (right_power),
        .color_found (color_found),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL pd_line_follower_steering_top");
            $finish;
        end
    end

    // The receiver alternates stall and free runs of random length; a requested
    // hold keeps it stalled for a long fixed stretch.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (!rx_stall_on)
        begin
            out_stall <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left <= run_left - 1;
        end
        else
        begin
            out_stall <= ~out_stall;
            run_left <= out_stall ? $urandom_range(0, 30) : $urandom_range(0, 20);
        end
    end

    function automatic int clamp_sym(input int v, input int lim);
        int mag;
        mag = (lim < 0) ? -lim : lim;
        if (v > mag)
            return mag;
        if (v < -mag)
            return -mag;
        return v;
    endfunction

    function automatic wheels_t steer_sample(input sample_t s);
        int      r, g, b, lvl, perr, derr, dir, pwr, steer, mag, diff, inner;
        bit      is_red, is_blue, stop_now;
        wheels_t w;
        r = s.red;
        g = s.green;
        b = s.blue;
        lvl = s.level;
        is_red = (r > 2 * g) && (r > 2 * b);
        is_blue = (b > 2 * r) && (b > g);
        stop_now = (stop_set == STOP_RED && is_red) || (stop_set == STOP_BLUE && is_blue);
        perr = int'(level_set) - lvl;
        derr = int'(last_level) - lvl;
        dir = (perr * int'(kp_set) + derr * int'(kd_set)) / GAIN_DIV;
        pwr = clamp_sym(int'(speed_set), MAG_LIMIT);
        steer = clamp_sym(dir, MAG_LIMIT);
        mag = (steer < 0) ? -steer : steer;
        diff = pwr * mag / MIX_DIV;
        inner = clamp_sym(pwr - diff, pwr);
        w.left = (steer >= 0) ? pwr[7:0] : inner[7:0];
        w.right = (steer >= 0) ? inner[7:0] : pwr[7:0];
        w.found = stop_now;
        last_level = stop_now ? 7'd0 : s.level;
        return w;
    endfunction

    function automatic sample_t mk_sample(input int lvl, input int r, input int g, input int b);
        sample_t s;
        s.level = 7'(lvl);
        s.red = 10'(r);
        s.green = 10'(g);
        s.blue = 10'(b);
        return s;
    endfunction

    // Mostly a line being followed: the level drifts around the edge, with
    // color markers mixed in; the rest is arbitrary noise.
    function automatic sample_t pick_sample();
        int lvl, r, g, b, base;
        if ($urandom_range(0, 9) < 7)
        begin
            walk_level = walk_level + int'($urandom_range(0, 30)) - 15;
            if (walk_level < 0)
                walk_level = 0;
            if (walk_level > 100)
                walk_level = 100;
            lvl = walk_level;
        end
        else
        begin
            lvl = $urandom_range(0, 127);
        end
        case ($urandom_range(0, 9))
            0, 1:
            begin
                g = $urandom_range(0, 340);
                b = $urandom_range(0, 340);
                r = $urandom_range(((g > b) ? 2 * g : 2 * b) + 1, 1023);
            end
            2:
            begin
                r = $urandom_range(0, 340);
                g = $urandom_range(0, 1000);
                b = $urandom_range(((2 * r > g) ? 2 * r : g) + 1, 1023);
            end
            3:
            begin
                r = $urandom_range(0, 300);
                g = $urandom_range(2 * r + 1, 1000);
                b = $urandom_range(0, 1) ? g : 2 * r;
                if ($urandom_range(0, 1))
                begin
                    g = $urandom_range(0, 511);
                    b = $urandom_range(0, g);
                    r = 2 * g;
                end
            end
            4, 5:
            begin
                r = $urandom_range(0, 1023);
                g = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            default:
            begin
                base = $urandom_range(0, 900);
                r = base + int'($urandom_range(0, 100));
                g = base + int'($urandom_range(0, 100));
                b = base + int'($urandom_range(0, 100));
            end
        endcase
        return mk_sample(lvl, r, g, b);
    endfunction

    task automatic send_sample(input sample_t s);
        in_valid <= 1'b1;
        reflect <= s.level;
        red_raw <= s.red;
        green_raw <= s.green;
        blue_raw <= s.blue;
        do
            @(posedge clk);
        while (in_stall);
        wheel_cmds_due.push_back(steer_sample(s));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SPEED:        speed_set = data[7:0];
            REG_TARGET_LEVEL: level_set = data[6:0];
            REG_KP_TENTHS:    kp_set = data[7:0];
            REG_KD_TENTHS:    kd_set = data;
            REG_HALT_COLOR:   stop_set = data[1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (wheel_cmds_due.size() != 0)
            @(posedge clk);
    endtask

    // Unused upper bits of each write carry random junk; the kd write has none.
    task automatic apply_settings(input settings_t s);
        wait_all_results();
        write_reg(REG_SPEED, {3'($urandom), 8'(s.speed)});
        write_reg(REG_TARGET_LEVEL, {4'($urandom), 7'(s.level)});
        write_reg(REG_KP_TENTHS, {3'($urandom), 8'(s.kp)});
        write_reg(REG_KD_TENTHS, 11'(s.kd));
        write_reg(REG_HALT_COLOR, {9'($urandom), 2'(s.stop)});
    endtask

    task automatic run_items(input int n);
        int sent, burst, gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                send_sample(pick_sample());
                sent++;
            end
            if (tx_idle_on)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(mk_sample(50, 0, 0, 0));
        send_sample(mk_sample(50, 0, 0, 0));
        send_sample(mk_sample(0, 1023, 1023, 1023));
        send_sample(mk_sample(100, 10, 20, 30));
        send_sample(mk_sample(127, 512, 256, 128));
        send_sample(mk_sample(40, 1023, 100, 100));
        send_sample(mk_sample(50, 0, 0, 0));
        send_sample(mk_sample(60, 200, 100, 0));
        send_sample(mk_sample(30, 201, 100, 100));
        in_valid <= 1'b0;
    endtask

    task automatic test_stop_colors();
        logic [1:0] codes[4];
        codes = '{STOP_NONE, STOP_RED, STOP_BLUE, STOP_SPARE};
        foreach (codes[i])
        begin
            wait_all_results();
            write_reg(REG_HALT_COLOR, 11'(codes[i]));
            send_sample(mk_sample(45, 900, 300, 200));
            send_sample(mk_sample(55, 100, 500, 1023));
            send_sample(mk_sample(65, 100, 300, 300));
            in_valid <= 1'b0;
        end
    endtask

    task automatic test_unused_indexes();
        wait_all_results();
        for (int i = REG_UNUSED_FIRST; i <= REG_INDEX_TOP; i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_sample(mk_sample(20, 0, 0, 1023));
        send_sample(mk_sample(80, 1023, 0, 0));
        in_valid <= 1'b0;
    endtask

    task automatic test_setting_extremes();
        settings_t corners[6];
        corners = '{
            '{127, 127, 255, 2047, STOP_RED},
            '{-128, 0, 0, 0, STOP_BLUE},
            '{100, 0, 255, 0, STOP_NONE},
            '{-100, 100, 0, 2047, STOP_SPARE},
            '{0, 50, 19, 1000, STOP_RED},
            '{-1, 100, 1, 1, STOP_BLUE}
        };
        foreach (corners[i])
        begin
            apply_settings(corners[i]);
            run_items(16);
        end
    endtask

    task automatic test_random_phases();
        settings_t s;
        for (int p = 0; p < 20; p++)
        begin
            case ($urandom_range(0, 5))
                0:       s.speed = $urandom_range(0, 1) ? -128 : 127;
                1:       s.speed = int'($urandom_range(0, 255)) - 128;
                default: s.speed = int'($urandom_range(0, 200)) - 100;
            endcase
            s.level = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(20, 80);
            s.kp = $urandom_range(0, 255);
            s.kd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
            s.stop = $urandom_range(0, 3);
            apply_settings(s);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_INDEX_TOP)),
                          CFG_DATA_W'($urandom));
            run_items($urandom_range(50, 90));
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while the sender keeps offering; then the sender waits for all
    // results before going on.
    task automatic test_backpressure();
        wait_all_results();
        tx_idle_on = 1'b0;
        holds_asked <= holds_asked + 1;
        run_items(40);
        wait_all_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_no_idle();
        wait_all_results();
        tx_idle_on = 1'b0;
        rx_stall_on <= 1'b0;
        run_items(150);
        wait_all_results();
        tx_idle_on = 1'b1;
        rx_stall_on <= 1'b1;
    endtask

    task automatic note_mismatch(input string what, input wheels_t want, input wheels_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected left %0d right %0d found %0b,",
                      " got left %0d right %0d found %0b"},
                     $realtime, what, want.left, want.right, want.found,
                     got.left, got.right, got.found);
    endtask

    always @(posedge clk)
    begin : check_results
        wheels_t want;
        wheels_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.left = left_power;
            got.right = right_power;
            got.found = color_found;
            if (wheel_cmds_due.size() == 0)
            begin
                note_mismatch("transaction with nothing expected", '0, got);
            end
            else
            begin
                want = wheel_cmds_due.pop_front();
                if (got.left !== want.left || got.right !== want.right
                    || got.found !== want.found)
                    note_mismatch("wheel command mismatch", want, got);
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_stop_colors();
        test_unused_indexes();
        test_setting_extremes();
        test_random_phases();
        test_backpressure();
        test_no_idle();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && wheel_cmds_due.size() == 0)
            $display("PASS pd_line_follower_steering_top");
        else
            $display("FAIL pd_line_follower_steering_top");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/plf_pkg.sv
rtl/core/plf_serial_mul.sv
rtl/core/plf_serial_div.sv
rtl/core/plf_color_detect.sv
rtl/core/pd_line_follower_steering_top.sv
sim/tb_pd_line_follower_steering_top.sv
